// ----- hdl/rtes_pkg.sv -----
// ----------------------------------------------------------------------------
// rtes_pkg: shared types and codes for the task and event scheduler
// Holds request codes, error codes, slot states and the queue word type.
// ----------------------------------------------------------------------------
package rtes_pkg;

  localparam int TaskSlotsDefault  = 16;
  localparam int EventSlotsDefault = 16;

  typedef enum logic [3:0] {
    FN_CREATE = 4'd0, FN_TERM = 4'd1, FN_SUSPEND = 4'd2, FN_RESUME = 4'd3,
    FN_SLEEP = 4'd4, FN_NEWEV = 4'd5, FN_WAIT = 4'd6, FN_SIGNAL = 4'd7,
    FN_YIELD = 4'd8, FN_TICK = 4'd9, FN_START = 4'd10, FN_READ = 4'd11,
    FN_CLEAR = 4'd12, FN_BAD = 4'd13
  } func_t;

  localparam logic [3:0] ERR_OK        = 4'd0;
  localparam logic [3:0] ERR_TFULL     = 4'd1;
  localparam logic [3:0] ERR_NOPID     = 4'd2;
  localparam logic [3:0] ERR_NOSUSP    = 4'd3;
  localparam logic [3:0] ERR_NOTSUSP   = 4'd4;
  localparam logic [3:0] ERR_EFULL     = 4'd5;
  localparam logic [3:0] ERR_BADID     = 4'd6;
  localparam logic [3:0] ERR_NOEV      = 4'd7;
  localparam logic [3:0] ERR_BUSY      = 4'd8;
  localparam logic [3:0] ERR_UNOWNED   = 4'd9;
  localparam logic [3:0] ERR_NOTWAIT   = 4'd10;
  localparam logic [3:0] ERR_BADREQ    = 4'd11;

  localparam logic [2:0] ST_DEAD      = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_SUSPENDED = 3'd3;
  localparam logic [2:0] ST_SLEEPING  = 3'd4;
  localparam logic [2:0] ST_WAIT      = 3'd5;

  // Classified request word passed from the front end to the back end.
  typedef struct packed {
    func_t       func;
    logic [15:0] arg;
  } req_t;

endpackage

// ----- hdl/rtos_task_event_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// rtos_task_event_scheduler_unit: round-robin task and event scheduler
// Intake queue in front, table sequencer behind it.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Words
// request   in         start and not busy  func, arg
// result    out        done strobe         current_pid, idle, error_code,
//                                          new_id, event_count
//
// After a request is accepted it passes the intake queue, a sweep of the task
// or event table where the request needs one, an execute step, and for some
// requests a dispatch scan or the owner lookup of a signal, before the result
// strobe is registered. The table sweeps go one slot per cycle.
// Reset is synchronous and clears all tables.
// busy stays high through the result strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rtos_task_event_scheduler_unit
  import rtes_pkg::*;
#(
  parameter int TASK_SLOTS  = TaskSlotsDefault,
  parameter int EVENT_SLOTS = EventSlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic [15:0] arg,
  output logic        done,
  output logic [15:0] current_pid,
  output logic        idle,
  output logic [3:0]  error_code,
  output logic [15:0] new_id,
  output logic [15:0] event_count
);

  logic fbusy;
  logic q_valid;
  logic q_pop;
  req_t q_word;
  logic pending;

  // Busy covers the whole life of a request until its result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (start && !busy) begin
      pending <= 1'b1;
    end else if (done) begin
      pending <= 1'b0;
    end
  end

  assign busy = fbusy || pending;

  rtes_front u_front (
    .clk(clk), .rst(rst), .start(start), .func(func), .arg(arg),
    .busy(fbusy), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
    .done(done)
  );

  rtes_back #(.TASK_SLOTS(TASK_SLOTS), .EVENT_SLOTS(EVENT_SLOTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
    .done(done), .current_pid(current_pid), .idle(idle),
    .error_code(error_code), .new_id(new_id), .event_count(event_count)
  );

endmodule

// ----- hdl/rtes_front.sv -----
// ----------------------------------------------------------------------------
// rtes_front: request intake
// Accepts a command word, classifies unknown requests and pushes it into a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rtes_front
  import rtes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [3:0]  func,
  input  logic [15:0] arg,
  output logic        busy,
  output logic        q_valid,
  output req_t        q_word,
  input  logic        q_pop,
  input  logic        done
);

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  req_t       in_word;
  logic       outstanding;

  // Any request the block does not know collapses to one code.
  always_comb begin
    in_word.arg = arg;
    if (func > 4'd12) begin
      in_word.func = FN_BAD;
    end else begin
      in_word.func = func_t'(func);
    end
  end

  // One request in flight at a time keeps results in order with the state.
  assign busy    = (fill != 2'd0) || outstanding;
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
      outstanding <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
      // A request stays outstanding from acceptance until its result word.
      if (push) begin
        outstanding <= 1'b1;
      end else if (done) begin
        outstanding <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> fill != 2'd2) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> fill != 2'd0) else $error("queue underflow");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("queue fill out of range");
`endif

endmodule

// ----- hdl/rtes_back.sv -----
// ----------------------------------------------------------------------------
// rtes_back: request execution
// Sequencer that walks the task and event tables one slot a cycle to look
// up, update and dispatch, then issues one result word.
// ----------------------------------------------------------------------------
module rtes_back
  import rtes_pkg::*;
#(
  parameter int TASK_SLOTS  = TaskSlotsDefault,
  parameter int EVENT_SLOTS = EventSlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  req_t        q_word,
  output logic        q_pop,
  output logic        done,
  output logic [15:0] current_pid,
  output logic        idle,
  output logic [3:0]  error_code,
  output logic [15:0] new_id,
  output logic [15:0] event_count
);

  localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int SW = (TASK_SLOTS > EVENT_SLOTS) ? TW + 1 : EW + 1;
  localparam logic [TW:0] TLAST = (TW+1)'(TASK_SLOTS - 1);
  localparam logic [EW:0] ELAST = (EW+1)'(EVENT_SLOTS - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TSCAN = 8'b0000_0010,
    S_ESCAN = 8'b0000_0100,
    S_EXEC  = 8'b0000_1000,
    S_OSCAN = 8'b0001_0000,
    S_TICK  = 8'b0010_0000,
    S_DISP  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Task table in flip-flops, swept one slot a cycle.
  logic [2:0]  st    [TASK_SLOTS];
  logic [2:0]  sv    [TASK_SLOTS];
  logic [15:0] pid   [TASK_SLOTS];
  logic [15:0] ticks [TASK_SLOTS];
  logic [15:0] ev_id  [EVENT_SLOTS];
  logic [15:0] ev_own [EVENT_SLOTS];
  logic [15:0] ev_sig [EVENT_SLOTS];

  state_t      state;
  req_t        req;
  logic [SW-1:0] idx;
  logic [TW-1:0] next_slot;
  logic [TW-1:0] run_slot;
  logic        run_valid;
  logic [15:0] pid_counter;
  logic [15:0] event_counter;
  logic        started;
  logic        found;
  logic [TW-1:0] fslot;
  logic        efound;
  logic [EW-1:0] eslot;
  logic        live;
  logic [3:0]  err;
  logic [15:0] nid;
  logic [15:0] cnt;
  logic        do_disp;
  logic [15:0] key;
  logic [TW-1:0] ti;
  logic [EW-1:0] ei;
  logic [TW-1:0] di;

  assign ti = idx[TW-1:0];
  assign ei = idx[EW-1:0];
  assign di = TW'((TW+1)'(next_slot) + (TW+1)'(idx[TW-1:0]) >= (TW+1)'(TASK_SLOTS)
               ? (TW+1)'(next_slot) + (TW+1)'(idx[TW-1:0]) - (TW+1)'(TASK_SLOTS)
               : (TW+1)'(next_slot) + (TW+1)'(idx[TW-1:0]));

  assign q_pop = (state == S_IDLE) && q_valid;

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      run_valid <= 1'b0;
      next_slot <= '0;
      run_slot <= '0;
      pid_counter <= '0;
      event_counter <= '0;
      started <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        st[i] <= ST_DEAD;
        pid[i] <= '0;
        sv[i] <= '0;
        ticks[i] <= '0;
      end
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        ev_id[i] <= '0;
        ev_own[i] <= '0;
        ev_sig[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            req <= q_word;
            idx <= '0;
            found <= 1'b0;
            efound <= 1'b0;
            live <= 1'b0;
            err <= ERR_OK;
            nid <= '0;
            cnt <= '0;
            do_disp <= 1'b0;
            key <= q_word.arg;
            if ((q_word.func == FN_TERM || q_word.func == FN_SLEEP ||
                 q_word.func == FN_WAIT || q_word.func == FN_YIELD) && !run_valid) begin
              err <= ERR_BADREQ;
              state <= S_DONE;
            end else begin
              case (q_word.func)
                FN_CREATE, FN_SUSPEND, FN_RESUME, FN_START: state <= S_TSCAN;
                FN_NEWEV, FN_WAIT, FN_SIGNAL, FN_READ, FN_CLEAR: begin
                  if (q_word.func != FN_NEWEV && q_word.arg == 16'd0) begin
                    err <= ERR_BADID;
                    if (q_word.func == FN_WAIT) begin
                      st[run_slot] <= ST_READY;
                      idx <= '0;
                      state <= S_DISP;
                    end else begin
                      state <= S_DONE;
                    end
                  end else begin
                    key <= (q_word.func == FN_NEWEV) ? 16'd0 : q_word.arg;
                    state <= S_ESCAN;
                  end
                end
                FN_TICK: state <= S_TICK;
                FN_BAD: begin
                  err <= ERR_BADREQ;
                  state <= S_DONE;
                end
                default: state <= S_EXEC;
              endcase
            end
          end
        end
        // Task scan: first dead slot, first pid match, or any live slot.
        S_TSCAN: begin
          if (!found) begin
            if (req.func == FN_CREATE && st[ti] == ST_DEAD) begin
              found <= 1'b1;
              fslot <= ti;
            end else if (req.func != FN_CREATE && req.func != FN_START &&
                         key != 16'd0 && pid[ti] == key) begin
              found <= 1'b1;
              fslot <= ti;
            end
          end
          if (st[ti] != ST_DEAD) begin
            live <= 1'b1;
          end
          if (idx == SW'(TLAST)) begin
            state <= S_EXEC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // Event scan: first slot with matching id (0 finds a free slot).
        S_ESCAN: begin
          if (!efound && ev_id[ei] == key) begin
            efound <= 1'b1;
            eslot <= ei;
          end
          if (idx == SW'(ELAST)) begin
            state <= S_EXEC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EXEC: begin
          idx <= '0;
          state <= S_DONE;
          case (req.func)
            FN_CREATE: begin
              if (!found) begin
                err <= ERR_TFULL;
              end else begin
                pid_counter <= (pid_counter == 16'hFFFF) ? 16'd1 : pid_counter + 16'd1;
                pid[fslot] <= (pid_counter == 16'hFFFF) ? 16'd1 : pid_counter + 16'd1;
                nid <= (pid_counter == 16'hFFFF) ? 16'd1 : pid_counter + 16'd1;
                st[fslot] <= ST_READY;
                sv[fslot] <= '0;
                ticks[fslot] <= '0;
              end
            end
            FN_TERM: begin
              st[run_slot] <= ST_DEAD;
              state <= S_DISP;
            end
            FN_SUSPEND: begin
              if (!found) begin
                err <= ERR_NOPID;
              end else if (st[fslot] == ST_DEAD || st[fslot] == ST_SUSPENDED) begin
                err <= ERR_NOSUSP;
              end else if (run_valid && fslot == run_slot) begin
                sv[fslot] <= ST_READY;
                st[fslot] <= ST_SUSPENDED;
                state <= S_DISP;
              end else begin
                sv[fslot] <= st[fslot];
                st[fslot] <= ST_SUSPENDED;
              end
            end
            FN_RESUME: begin
              if (!found) begin
                err <= ERR_NOPID;
              end else if (st[fslot] != ST_SUSPENDED) begin
                err <= ERR_NOTSUSP;
              end else begin
                st[fslot] <= sv[fslot];
                sv[fslot] <= ST_SUSPENDED;
              end
            end
            FN_SLEEP: begin
              st[run_slot] <= ST_SLEEPING;
              ticks[run_slot] <= req.arg;
              state <= S_DISP;
            end
            FN_NEWEV: begin
              if (event_counter >= 16'(EVENT_SLOTS) || !efound) begin
                err <= ERR_EFULL;
              end else begin
                event_counter <= event_counter + 16'd1;
                ev_id[eslot] <= event_counter + 16'd1;
                ev_own[eslot] <= '0;
                ev_sig[eslot] <= '0;
                nid <= event_counter + 16'd1;
              end
            end
            FN_WAIT: begin
              if (!efound) begin
                err <= ERR_NOEV;
                st[run_slot] <= ST_READY;
              end else if (ev_own[eslot] != 16'd0 && ev_own[eslot] != pid[run_slot]) begin
                err <= ERR_BUSY;
                st[run_slot] <= ST_READY;
              end else begin
                ev_own[eslot] <= pid[run_slot];
                st[run_slot] <= ST_WAIT;
              end
              state <= S_DISP;
            end
            FN_SIGNAL: begin
              if (!efound) begin
                err <= ERR_NOEV;
              end else if (ev_own[eslot] == 16'd0) begin
                err <= ERR_UNOWNED;
              end else begin
                if (ev_sig[eslot] != 16'hFFFF) begin
                  ev_sig[eslot] <= ev_sig[eslot] + 16'd1;
                end
                key <= ev_own[eslot];
                found <= 1'b0;
                state <= S_OSCAN;
              end
            end
            FN_YIELD: begin
              st[run_slot] <= ST_READY;
              state <= S_DISP;
            end
            FN_START: begin
              if (!started && live) begin
                started <= 1'b1;
                state <= S_DISP;
              end
            end
            FN_READ: begin
              if (!efound) begin
                err <= ERR_NOEV;
              end else begin
                cnt <= ev_sig[eslot];
              end
            end
            FN_CLEAR: begin
              if (!efound) begin
                err <= ERR_NOEV;
              end else begin
                ev_sig[eslot] <= '0;
              end
            end
            default: err <= ERR_BADREQ;
          endcase
        end
        // Owner lookup for a signal; owner pid is never zero here.
        S_OSCAN: begin
          if (!found && pid[ti] == key) begin
            found <= 1'b1;
            fslot <= ti;
          end
          if (idx == SW'(TLAST)) begin
            state <= S_DONE;
            if (found || pid[ti] == key) begin
              if (found) begin
                if (st[fslot] == ST_WAIT) begin
                  st[fslot] <= ST_READY;
                end else if (!(st[fslot] == ST_SUSPENDED && sv[fslot] == ST_WAIT)) begin
                  err <= ERR_NOTWAIT;
                end
              end else begin
                if (st[ti] == ST_WAIT) begin
                  st[ti] <= ST_READY;
                end else if (!(st[ti] == ST_SUSPENDED && sv[ti] == ST_WAIT)) begin
                  err <= ERR_NOTWAIT;
                end
              end
            end else begin
              err <= ERR_NOTWAIT;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // Tick countdown, one slot a cycle.
        S_TICK: begin
          if (st[ti] == ST_SLEEPING) begin
            if (ticks[ti] <= 16'd1) begin
              ticks[ti] <= '0;
              st[ti] <= ST_READY;
            end else begin
              ticks[ti] <= ticks[ti] - 16'd1;
            end
          end else if (st[ti] == ST_SUSPENDED && sv[ti] == ST_SLEEPING) begin
            if (ticks[ti] <= 16'd1) begin
              ticks[ti] <= '0;
              sv[ti] <= ST_READY;
            end else begin
              ticks[ti] <= ticks[ti] - 16'd1;
            end
          end
          if (idx == SW'(TLAST)) begin
            idx <= '0;
            state <= (started && !run_valid) ? S_DISP : S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // Round-robin dispatch from next_slot.
        S_DISP: begin
          if (idx == '0) begin
            run_valid <= 1'b0;
          end
          if (st[di] == ST_READY) begin
            st[di] <= ST_RUNNING;
            run_slot <= di;
            run_valid <= 1'b1;
            next_slot <= (di == TLAST[TW-1:0]) ? '0 : di + 1'b1;
            state <= S_DONE;
          end else if (idx == SW'(TLAST)) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          current_pid <= run_valid ? pid[run_slot] : 16'd0;
          idle <= !run_valid;
          error_code <= err;
          new_id <= nid;
          event_count <= cnt;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_run_is_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && run_valid) |-> st[run_slot] == ST_RUNNING)
    else $error("running slot not in running state");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state != S_IDLE) else $error("pop without start of work");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the round-robin task and event scheduler
// Drives request words (func, arg) through the start/busy handshake, keeps
// a cycle-free model of the task and event tables, and compares every
// result strobe field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_top;
  import rtes_pkg::*;

  localparam int NumTasks   = TaskSlotsDefault;
  localparam int NumEvents  = EventSlotsDefault;
  localparam int IdleLimit  = 4000;
  localparam int RandItems  = 1700;

  // One result word as the block reports it.
  typedef struct packed {
    logic [15:0] pid;
    logic        idl;
    logic [3:0]  err;
    logic [15:0] nid;
    logic [15:0] cnt;
  } sched_word_t;

  // Scoreboard: owns the table model and the queue of predicted words.
  class sched_scoreboard;
    logic [2:0]  st [NumTasks];
    logic [2:0]  saved [NumTasks];
    logic [15:0] pid [NumTasks];
    logic [15:0] ticks [NumTasks];
    logic [15:0] ev_id [NumEvents];
    logic [15:0] ev_owner [NumEvents];
    logic [15:0] ev_sig [NumEvents];
    int          next_idx;
    bit          run_ok;
    int          run_idx;
    logic [15:0] pid_ctr;
    logic [15:0] ev_ctr;
    bit          started;
    sched_word_t pending[$];
    int          mismatches;

    function new();
      for (int i = 0; i < NumTasks; i++) begin
        st[i] = ST_DEAD; saved[i] = 0; pid[i] = 0; ticks[i] = 0;
      end
      for (int i = 0; i < NumEvents; i++) begin
        ev_id[i] = 0; ev_owner[i] = 0; ev_sig[i] = 0;
      end
      next_idx = 0; run_ok = 0; run_idx = 0;
      pid_ctr = 0; ev_ctr = 0; started = 0; mismatches = 0;
    endfunction

    function void pick_next();
      int s;
      run_ok = 0;
      for (int k = 0; k < NumTasks; k++) begin
        s = (next_idx + k) % NumTasks;
        if (st[s] == ST_READY) begin
          st[s] = ST_RUNNING; run_idx = s; run_ok = 1;
          next_idx = (s + 1) % NumTasks;
          return;
        end
      end
    endfunction

    function int lookup_pid(logic [15:0] p);
      if (p == 0) return NumTasks;
      for (int s = 0; s < NumTasks; s++) if (pid[s] == p) return s;
      return NumTasks;
    endfunction

    function int lookup_event(logic [15:0] id, ref logic [3:0] err);
      if (id == 0) begin err = ERR_BADID; return NumEvents; end
      for (int e = 0; e < NumEvents; e++) if (ev_id[e] == id) return e;
      err = ERR_NOEV;
      return NumEvents;
    endfunction

    // Apply one accepted request to the model and queue its result.
    function void note_request(logic [3:0] fn, logic [15:0] a);
      sched_word_t w;
      logic [3:0]  err;
      logic [15:0] me;
      int          s, e;
      bit          live;
      err = ERR_OK; w = '0;
      if ((fn == FN_TERM || fn == FN_SLEEP || fn == FN_WAIT || fn == FN_YIELD) && !run_ok)
        err = ERR_BADREQ;
      else begin
        case (fn)
          FN_CREATE: begin
            s = NumTasks;
            for (int i = NumTasks - 1; i >= 0; i--) if (st[i] == ST_DEAD) s = i;
            if (s == NumTasks) err = ERR_TFULL;
            else begin
              pid_ctr = pid_ctr + 1;
              if (pid_ctr == 0) pid_ctr = 1;
              pid[s] = pid_ctr; st[s] = ST_READY; saved[s] = 0; ticks[s] = 0;
              w.nid = pid_ctr;
            end
          end
          FN_TERM: begin
            st[run_idx] = ST_DEAD; pick_next();
          end
          FN_SUSPEND: begin
            s = lookup_pid(a);
            if (s == NumTasks) err = ERR_NOPID;
            else if (st[s] == ST_DEAD || st[s] == ST_SUSPENDED) err = ERR_NOSUSP;
            else if (run_ok && s == run_idx) begin
              saved[s] = ST_READY; st[s] = ST_SUSPENDED; pick_next();
            end else begin
              saved[s] = st[s]; st[s] = ST_SUSPENDED;
            end
          end
          FN_RESUME: begin
            s = lookup_pid(a);
            if (s == NumTasks) err = ERR_NOPID;
            else if (st[s] != ST_SUSPENDED) err = ERR_NOTSUSP;
            else begin
              st[s] = saved[s]; saved[s] = ST_SUSPENDED;
            end
          end
          FN_SLEEP: begin
            st[run_idx] = ST_SLEEPING; ticks[run_idx] = a; pick_next();
          end
          FN_NEWEV: begin
            e = NumEvents;
            for (int i = NumEvents - 1; i >= 0; i--) if (ev_id[i] == 0) e = i;
            if (ev_ctr >= NumEvents || e == NumEvents) err = ERR_EFULL;
            else begin
              ev_ctr = ev_ctr + 1;
              ev_id[e] = ev_ctr; ev_owner[e] = 0; ev_sig[e] = 0;
              w.nid = ev_ctr;
            end
          end
          FN_WAIT: begin
            me = pid[run_idx];
            e = lookup_event(a, err);
            if (e < NumEvents) begin
              if (ev_owner[e] != 0 && ev_owner[e] != me) err = ERR_BUSY;
              else begin
                ev_owner[e] = me; st[run_idx] = ST_WAIT;
              end
            end
            if (err != ERR_OK) st[run_idx] = ST_READY;
            pick_next();
          end
          FN_SIGNAL: begin
            e = lookup_event(a, err);
            if (e < NumEvents) begin
              if (ev_owner[e] == 0) err = ERR_UNOWNED;
              else begin
                if (ev_sig[e] != 16'hFFFF) ev_sig[e]++;
                s = lookup_pid(ev_owner[e]);
                if (s == NumTasks) err = ERR_NOTWAIT;
                else if (st[s] == ST_WAIT) st[s] = ST_READY;
                else if (!(st[s] == ST_SUSPENDED && saved[s] == ST_WAIT)) err = ERR_NOTWAIT;
              end
            end
          end
          FN_YIELD: begin
            st[run_idx] = ST_READY; pick_next();
          end
          FN_TICK: begin
            for (int i = 0; i < NumTasks; i++) begin
              if (st[i] == ST_SLEEPING) begin
                if (ticks[i] <= 1) begin ticks[i] = 0; st[i] = ST_READY; end
                else ticks[i]--;
              end else if (st[i] == ST_SUSPENDED && saved[i] == ST_SLEEPING) begin
                if (ticks[i] <= 1) begin ticks[i] = 0; saved[i] = ST_READY; end
                else ticks[i]--;
              end
            end
            if (started && !run_ok) pick_next();
          end
          FN_START: begin
            live = 0;
            for (int i = 0; i < NumTasks; i++) if (st[i] != ST_DEAD) live = 1;
            if (!started && live) begin started = 1; pick_next(); end
          end
          FN_READ: begin
            e = lookup_event(a, err);
            if (e < NumEvents) w.cnt = ev_sig[e];
          end
          FN_CLEAR: begin
            e = lookup_event(a, err);
            if (e < NumEvents) ev_sig[e] = 0;
          end
          default: err = ERR_BADREQ;
        endcase
      end
      w.pid = run_ok ? pid[run_idx] : 16'd0;
      w.idl = !run_ok;
      w.err = err;
      pending.push_back(w);
    endfunction

    // Compare one strobed result with the oldest predicted word.
    function void check_result(sched_word_t got);
      sched_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.pid !== exp_w.pid || got.idl !== exp_w.idl || got.err !== exp_w.err ||
          got.nid !== exp_w.nid || got.cnt !== exp_w.cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pid %0d/%0d idle %0d/%0d err %0d/%0d id %0d/%0d cnt %0d/%0d (exp/act)",
                   exp_w.pid, got.pid, exp_w.idl, got.idl, exp_w.err, got.err,
                   exp_w.nid, got.nid, exp_w.cnt, got.cnt);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [3:0]  func = 0;
  logic [15:0] arg = 0;
  logic        busy, done, idle;
  logic [15:0] current_pid, new_id, event_count;
  logic [3:0]  error_code;

  sched_scoreboard sb = new();
  int  quiet_cycles = 0;
  bit  gaps_on = 1;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  rtos_task_event_scheduler_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .arg(arg),
    .done(done), .current_pid(current_pid), .idle(idle), .error_code(error_code),
    .new_id(new_id), .event_count(event_count)
  );

  // Result monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result({current_pid, idle, error_code, new_id, event_count});
        quiet_cycles <= 0;
      end else if (start && !busy) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IdleLimit) begin
        $display("rtos_task_event_scheduler_unit verification failed");
        $finish;
      end
    end
  end

  // Send one request word; optional random gap before it. Returns at the
  // edge that accepts the word, with start still high.
  task automatic send_word(logic [3:0] fn, logic [15:0] a);
    while (gaps_on && $urandom_range(0, 99) < 11) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; func <= fn; arg <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(fn, a);
  endtask

  // Argument likely to hit a live pid, an event id, or an edge value.
  function automatic logic [15:0] pick_arg(logic [3:0] fn);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom);
    if (r < 12) return (r < 10) ? 16'd0 : 16'hFFFF;
    if (fn == FN_SLEEP) return 16'($urandom_range(0, 4));
    if (fn inside {FN_NEWEV, FN_WAIT, FN_SIGNAL, FN_READ, FN_CLEAR})
      return 16'($urandom_range(1, 17));
    return (sb.pid_ctr > 3) ? sb.pid_ctr - 16'($urandom_range(0, 20))
                            : 16'($urandom_range(1, 20));
  endfunction

  initial begin
    logic [3:0] fn;
    int r;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: caller-less requests, empty lookups, then build-up.
    send_word(FN_TERM, 0);
    send_word(FN_YIELD, 0);
    send_word(FN_SLEEP, 16'hFFFF);
    send_word(FN_WAIT, 1);
    send_word(FN_START, 0);
    send_word(FN_BAD, 16'hAAAA);
    send_word(4'd15, 16'h5555);
    send_word(FN_SUSPEND, 0);
    send_word(FN_READ, 0);
    send_word(FN_SIGNAL, 3);
    send_word(FN_NEWEV, 0);
    send_word(FN_CREATE, 0);
    send_word(FN_CREATE, 0);
    send_word(FN_TICK, 0);
    send_word(FN_START, 0);
    send_word(FN_SIGNAL, 1);
    send_word(FN_WAIT, 1);
    send_word(FN_WAIT, 1);
    send_word(FN_SIGNAL, 1);
    send_word(FN_READ, 1);
    send_word(FN_CLEAR, 1);
    send_word(FN_SUSPEND, 1);
    send_word(FN_RESUME, 1);
    send_word(FN_SLEEP, 0);
    send_word(FN_TICK, 0);
    // Random part; a stretch in the middle runs without gaps.
    for (int n = 0; n < RandItems; n++) begin
      gaps_on = !(n >= 600 && n < 900);
      r = $urandom_range(0, 99);
      if (r < 3) fn = 4'($urandom_range(13, 15));
      else if (r < 14) fn = FN_TICK;
      else if (r < 22) fn = FN_CREATE;
      else fn = 4'($urandom_range(0, 12));
      send_word(fn, pick_arg(fn));
    end
    // Terminate whatever is still running.
    for (int n = 0; n < 40 && sb.run_ok; n++) send_word(FN_TERM, 0);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0)
      $display("rtos_task_event_scheduler_unit verification clean");
    else
      $display("rtos_task_event_scheduler_unit verification failed");
    $finish;
  end
endmodule
